/* hw/rtl/arp_pkg.sv */
// Shared types and constants for the ARP cache and responder.
`default_nettype none

package arp_pkg;

	// Default number of cache entries.
	localparam int ENTRIES_DEF = 8;

	// Field widths.
	localparam int MAC_W       = 48;
	localparam int IP_W        = 32;
	localparam int HDR_W       = 16;
	localparam int IN_DATA_W   = 208;
	localparam int OUT_DATA_W  = 80;
	localparam int CFG_DATA_W  = 48;

	// Header checks.
	localparam logic [HDR_W-1:0] MIN_FRAME_LEN = 16'd28;
	localparam logic [HDR_W-1:0] HW_ETHERNET   = 16'd1;
	localparam logic [HDR_W-1:0] PROTO_IPV4    = 16'h0800;
	localparam logic [HDR_W-1:0] OP_REQUEST    = 16'd1;

	// Register reset values.
	localparam logic [MAC_W-1:0] LOCAL_MAC_RESET = 48'h0200_0000_0002;
	localparam logic [IP_W-1:0]  LOCAL_IP_RESET  = 32'hC0A8_0002;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ACCEPT = 3'd0,
		ST_DROP   = 3'd1,
		ST_REPLY  = 3'd2,
		ST_HIT    = 3'd3,
		ST_MISS   = 3'd4
	} status_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_LOCAL_MAC = 1'b0,
		REG_LOCAL_IP  = 1'b1
	} reg_idx_t;

	// Token that walks the cell chain: one item in flight.
	typedef struct packed {
		logic             valid;
		logic             done;
		status_t          status;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} tok_t;

endpackage

`default_nettype wire

/* hw/rtl/arp_cell.sv */
// One cache cell: holds one IP/MAC entry and passes the token to its neighbor.
`default_nettype none

module arp_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire arp_pkg::tok_t tok_in,
	output arp_pkg::tok_t      tok_out
);

	logic [arp_pkg::IP_W-1:0]  ip_q;
	logic [arp_pkg::MAC_W-1:0] mac_q;
	arp_pkg::tok_t             tok_q;
	arp_pkg::tok_t             tok_nxt;
	logic                      learn;
	logic                      hit;

	// Match this entry against the passing token; the first match in chain order wins.
	always_comb begin
		learn = tok_in.valid && !tok_in.done &&
			(tok_in.status == arp_pkg::ST_ACCEPT || tok_in.status == arp_pkg::ST_REPLY) &&
			(ip_q == '0 || ip_q == tok_in.ip);
		hit = tok_in.valid && !tok_in.done && tok_in.status == arp_pkg::ST_MISS &&
			ip_q == tok_in.ip;
		tok_nxt = tok_in;
		if (hit) begin
			tok_nxt.status = arp_pkg::ST_HIT;
			tok_nxt.mac    = mac_q;
			tok_nxt.done   = 1'b1;
		end
		if (learn) begin
			tok_nxt.done = 1'b1;
		end
	end

	// Entry storage and the token register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q  <= '0;
			mac_q <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (learn) begin
				ip_q  <= tok_in.ip;
				mac_q <= tok_in.mac;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

/* hw/rtl/arp_cache_and_responder_top.sv */
// Top level of the ARP cache and responder: input checks, cell chain and result stage.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata header or lookup fields, s_tuser func
// m_*       out        m_tvalid/m_tready  m_tdata mac_out/ip_out, m_tuser status
// cfg_*     in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// An item enters a token register, then walks the chain of ENTRIES cells, one cell per cycle.
// The result passes from the last cell into the hold register and then into the output register;
// the next item is taken once the result has moved to the output register.
// Reset empties every cache entry at once.
// A stalled output keeps one result while the next item walks the chain.
`default_nettype none

module arp_cache_and_responder_top #(
	parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// frame_length[15:0], hw_type[31:16], proto_type[47:32], arp_opcode[63:48],
	// sender_mac[111:64], sender_ip[143:112], target_ip[175:144], lookup_ip[207:176]
	input  wire logic [arp_pkg::IN_DATA_W-1:0] s_tdata,
	// func[0]
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// mac_out[47:0], ip_out[79:48]
	output logic [arp_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status[2:0]
	output logic [2:0]                         m_tuser,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [arp_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Input fields.
	logic [arp_pkg::HDR_W-1:0] frame_length;
	logic [arp_pkg::HDR_W-1:0] hw_type;
	logic [arp_pkg::HDR_W-1:0] proto_type;
	logic [arp_pkg::HDR_W-1:0] arp_opcode;
	logic [arp_pkg::MAC_W-1:0] sender_mac;
	logic [arp_pkg::IP_W-1:0]  sender_ip;
	logic [arp_pkg::IP_W-1:0]  target_ip;
	logic [arp_pkg::IP_W-1:0]  lookup_ip;

	assign frame_length = s_tdata[15:0];
	assign hw_type      = s_tdata[31:16];
	assign proto_type   = s_tdata[47:32];
	assign arp_opcode   = s_tdata[63:48];
	assign sender_mac   = s_tdata[111:64];
	assign sender_ip    = s_tdata[143:112];
	assign target_ip    = s_tdata[175:144];
	assign lookup_ip    = s_tdata[207:176];

	// Configuration registers; the local MAC is stored but drives no output.
	logic [arp_pkg::MAC_W-1:0] local_mac_q;
	logic [arp_pkg::IP_W-1:0]  local_ip_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mac_q <= arp_pkg::LOCAL_MAC_RESET;
			local_ip_q  <= arp_pkg::LOCAL_IP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (arp_pkg::reg_idx_t'(cfg_index))
				arp_pkg::REG_LOCAL_MAC: local_mac_q <= cfg_data;
				arp_pkg::REG_LOCAL_IP:  local_ip_q  <= cfg_data[arp_pkg::IP_W-1:0];
				default: ;
			endcase
		end
	end

	// Classify the item and build the token that enters the chain.
	logic          busy_q;
	logic          in_accept;
	arp_pkg::tok_t tok_new;
	arp_pkg::tok_t tok_s0;

	assign s_tready  = !busy_q;
	assign in_accept = s_tvalid && s_tready;

	always_comb begin
		tok_new       = '0;
		tok_new.valid = in_accept;
		tok_new.mac   = sender_mac;
		tok_new.ip    = sender_ip;
		if (s_tuser) begin
			tok_new.status = arp_pkg::ST_MISS;
			tok_new.ip     = lookup_ip;
		end else if (frame_length < arp_pkg::MIN_FRAME_LEN || hw_type != arp_pkg::HW_ETHERNET ||
				proto_type != arp_pkg::PROTO_IPV4) begin
			tok_new.status = arp_pkg::ST_DROP;
		end else if (arp_opcode == arp_pkg::OP_REQUEST && target_ip == local_ip_q) begin
			tok_new.status = arp_pkg::ST_REPLY;
		end else begin
			tok_new.status = arp_pkg::ST_ACCEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
		end else begin
			tok_s0 <= tok_new;
		end
	end

	// Chain of cache cells.
	arp_pkg::tok_t chain [ENTRIES+1];

	assign chain[0] = tok_s0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		arp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	// Format the result from the token leaving the last cell.
	arp_pkg::tok_t             tok_end;
	logic [arp_pkg::MAC_W-1:0] res_mac;
	logic [arp_pkg::IP_W-1:0]  res_ip;

	assign tok_end = chain[ENTRIES];

	always_comb begin
		res_mac = '0;
		res_ip  = '0;
		if (tok_end.status == arp_pkg::ST_REPLY || tok_end.status == arp_pkg::ST_HIT) begin
			res_mac = tok_end.mac;
		end
		if (tok_end.status == arp_pkg::ST_REPLY) begin
			res_ip = tok_end.ip;
		end
	end

	// Result hold register and output register.
	logic                      res_valid_q;
	arp_pkg::status_t          res_status_q;
	logic [arp_pkg::MAC_W-1:0] res_mac_q;
	logic [arp_pkg::IP_W-1:0]  res_ip_q;
	logic                      out_valid_q;
	arp_pkg::status_t          out_status_q;
	logic [arp_pkg::MAC_W-1:0] out_mac_q;
	logic [arp_pkg::IP_W-1:0]  out_ip_q;
	logic                      res_move;

	assign res_move = res_valid_q && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (res_move) begin
				busy_q <= 1'b0;
			end
			if (tok_end.valid) begin
				res_valid_q <= 1'b1;
			end else if (res_move) begin
				res_valid_q <= 1'b0;
			end
			if (res_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end.valid) begin
			res_status_q <= tok_end.status;
			res_mac_q    <= res_mac;
			res_ip_q     <= res_ip;
		end
		if (res_move) begin
			out_status_q <= res_status_q;
			out_mac_q    <= res_mac_q;
			out_ip_q     <= res_ip_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_ip_q, out_mac_q};

endmodule

`default_nettype wire

/* hw/rtl/arp_chk.sv */
// Port-level checks for the ARP cache and responder, bound to the top level.
`default_nettype none

module arp_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [arp_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [2:0]                     m_tuser
);

	// One item at a time: after an input beat the block takes no further beat at once.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Drops, misses and plain accepts carry no addresses.
	a_empty_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == arp_pkg::ST_DROP || m_tuser == arp_pkg::ST_MISS ||
			m_tuser == arp_pkg::ST_ACCEPT) |-> m_tdata == '0)
		else $error("address data on a result without addresses");

	// Only a reply carries an IP address.
	a_ip_reply_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != arp_pkg::ST_REPLY |-> m_tdata[79:48] == '0)
		else $error("ip field set on a non-reply result");

endmodule

bind arp_cache_and_responder_top arp_chk u_arp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/arp_check.sv */
// Checker for the ARP cache and responder: predicts every result beat and compares it.
module arp_check #(
	parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [arp_pkg::IN_DATA_W-1:0]   s_tdata,
	input  wire logic                            s_tuser,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [arp_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  wire logic [2:0]                      m_tuser,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic                            cfg_index,
	input  wire logic [arp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                   fail_count,
	output int                                   pending
);
	import arp_pkg::*;

	typedef struct packed {
		status_t          status;
		logic [MAC_W-1:0] mac;
		logic [IP_W-1:0]  ip;
	} arp_answer_t;

	// Shadow copy of the cache and of the two local address registers.
	logic [IP_W-1:0]  cache_ip [ENTRIES];
	logic [MAC_W-1:0] cache_mac [ENTRIES];
	// The local MAC is tracked, but it never shows up in a result beat.
	logic [MAC_W-1:0] own_mac;
	logic [IP_W-1:0]  own_ip;
	arp_answer_t      awaited_answers [$];
	arp_answer_t      want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// Works out the answer to one input beat and updates the shadow cache.
	function automatic arp_answer_t resolve_arp(input logic is_lookup,
			input logic [IN_DATA_W-1:0] d);
		logic [HDR_W-1:0] len;
		logic [HDR_W-1:0] hw;
		logic [HDR_W-1:0] pt;
		logic [HDR_W-1:0] op;
		logic [MAC_W-1:0] smac;
		logic [IP_W-1:0]  sip;
		logic [IP_W-1:0]  tip;
		logic [IP_W-1:0]  lip;
		arp_answer_t      a;
		int               slot;
		len  = d[15:0];
		hw   = d[31:16];
		pt   = d[47:32];
		op   = d[63:48];
		smac = d[111:64];
		sip  = d[143:112];
		tip  = d[175:144];
		lip  = d[207:176];
		a.status = ST_ACCEPT;
		a.mac = '0;
		a.ip = '0;
		slot = -1;
		if (is_lookup) begin
			// The first slot whose IP matches wins; IP 0 matches an empty slot.
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot < 0 && cache_ip[i] == lip) slot = i;
			end
			if (slot >= 0) begin
				a.status = ST_HIT;
				a.mac = cache_mac[slot];
			end else begin
				a.status = ST_MISS;
			end
		end else if (len < MIN_FRAME_LEN || hw != HW_ETHERNET || pt != PROTO_IPV4) begin
			a.status = ST_DROP;
		end else begin
			// Learn the sender into the first empty or matching slot; a full cache skips it.
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot < 0 && (cache_ip[i] == '0 || cache_ip[i] == sip)) slot = i;
			end
			if (slot >= 0) begin
				cache_ip[slot] = sip;
				cache_mac[slot] = smac;
			end
			if (op == OP_REQUEST && tip == own_ip) begin
				a.status = ST_REPLY;
				a.mac = smac;
				a.ip = sip;
			end
		end
		return a;
	endfunction

	// Register writes, result comparison and prediction, all on the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				cache_ip[i] = '0;
				cache_mac[i] = '0;
			end
			own_mac = LOCAL_MAC_RESET;
			own_ip = LOCAL_IP_RESET;
			awaited_answers.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (reg_idx_t'(cfg_index) == REG_LOCAL_MAC) begin
					own_mac = cfg_data[MAC_W-1:0];
				end else begin
					own_ip = cfg_data[IP_W-1:0];
				end
			end
			if (m_tvalid && m_tready) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch($sformatf("result beat with none awaited, status %0d",
						m_tuser));
				end else begin
					want = awaited_answers.pop_front();
					if (m_tuser !== want.status)
						report_mismatch($sformatf("status %0d, wanted %0d",
							m_tuser, want.status));
					if (m_tdata[MAC_W-1:0] !== want.mac)
						report_mismatch($sformatf("mac_out %h, wanted %h",
							m_tdata[MAC_W-1:0], want.mac));
					if (m_tdata[MAC_W +: IP_W] !== want.ip)
						report_mismatch($sformatf("ip_out %h, wanted %h",
							m_tdata[MAC_W +: IP_W], want.ip));
				end
			end
			if (s_tvalid && s_tready)
				awaited_answers.push_back(resolve_arp(s_tuser, s_tdata));
		end
		pending = awaited_answers.size();
	end

endmodule

/* bench/tb.sv */
// Testbench top for the ARP cache and responder: clock, reset, stimulus and verdict.
module tb;
	import arp_pkg::*;

	localparam int   STALL_LIMIT = 2000;
	localparam logic FUNC_HEADER = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int              fail_count;
	int              pending;
	logic [IP_W-1:0] cur_local_ip;
	bit              sender_idles;
	bit              quiet_tail = 1'b0;
	int              hold_left = 0;
	int              stall_cycles = 0;

	arp_cache_and_responder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	arp_check #(.ENTRIES(ENTRIES_DEF)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	// Receiver side: random stall bursts, none in the closing phase.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			hold_left = $urandom_range(0, 9);
			m_tready = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	// Watchdog: ends the run when no channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [MAC_W-1:0] rnd48();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[MAC_W-1:0];
	endfunction

	// Packs the input fields, frame_length in the lowest bits.
	function automatic logic [IN_DATA_W-1:0] arp_frame(input logic [HDR_W-1:0] len,
			input logic [HDR_W-1:0] hw, input logic [HDR_W-1:0] pt,
			input logic [HDR_W-1:0] op, input logic [MAC_W-1:0] smac,
			input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip,
			input logic [IP_W-1:0] lip);
		return {lip, tip, sip, smac, op, pt, hw, len};
	endfunction

	// A header beat; the lookup field is noise.
	function automatic logic [IN_DATA_W-1:0] hdr(input logic [HDR_W-1:0] len,
			input logic [HDR_W-1:0] hw, input logic [HDR_W-1:0] pt,
			input logic [HDR_W-1:0] op, input logic [MAC_W-1:0] smac,
			input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
		return arp_frame(len, hw, pt, op, smac, sip, tip, $urandom);
	endfunction

	// A lookup beat; the header fields are noise.
	function automatic logic [IN_DATA_W-1:0] look(input logic [IP_W-1:0] lip);
		return arp_frame(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			rnd48(), $urandom, $urandom, lip);
	endfunction

	// Addresses lean on a small pool so that learned entries get hit and rewritten.
	function automatic logic [IP_W-1:0] pick_ip();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return cur_local_ip;
			2: return '1;
			3, 4, 5, 6: return 32'h0a00_0000 + 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed headers; one in five breaks a single check.
	function automatic logic [IN_DATA_W-1:0] random_header();
		logic [HDR_W-1:0] len;
		logic [HDR_W-1:0] hw;
		logic [HDR_W-1:0] pt;
		logic [HDR_W-1:0] op;
		int               r;
		len = 16'($urandom_range(28, 65535));
		if ($urandom_range(0, 9) == 0) len = MIN_FRAME_LEN;
		hw = HW_ETHERNET;
		pt = PROTO_IPV4;
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 2))
				0: len = 16'($urandom_range(0, 27));
				1: hw = 16'($urandom);
				default: pt = 16'($urandom);
			endcase
		end
		r = $urandom_range(0, 9);
		if (r < 5) op = OP_REQUEST;
		else if (r < 7) op = 16'd2;
		else op = 16'($urandom);
		return hdr(len, hw, pt, op, rnd48(), pick_ip(),
			($urandom_range(0, 2) == 0) ? cur_local_ip : pick_ip());
	endfunction

	// Sends one beat, possibly after an idle burst; called and returns at a falling edge.
	task automatic push_item(input logic func, input logic [IN_DATA_W-1:0] data);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = func;
		s_tdata = data;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Holds the sender off until every awaited result has come out.
	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_LOCAL_IP) cur_local_ip = value[IP_W-1:0];
	endtask

	// Random mix of lookups and headers, with idling switched per block of 50 beats.
	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) sender_idles = !quiet_tail && ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 9) < 3) push_item(FUNC_LOOKUP, look(pick_ip()));
			else push_item(FUNC_HEADER, random_header());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = FUNC_HEADER;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LOCAL_MAC;
		cfg_data = '0;
		cur_local_ip = LOCAL_IP_RESET;
		sender_idles = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Empty cache: IP 0 hits the first empty slot, anything else misses.
		push_item(FUNC_LOOKUP, look('0));
		push_item(FUNC_LOOKUP, look('1));
		// Each header check on its own, at its edges.
		push_item(FUNC_HEADER, hdr(16'd27, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rnd48(),
			32'h0a00_0001, cur_local_ip));
		push_item(FUNC_HEADER, hdr(16'd0, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rnd48(),
			32'h0a00_0001, cur_local_ip));
		push_item(FUNC_HEADER, hdr(MIN_FRAME_LEN, 16'h0000, PROTO_IPV4, OP_REQUEST, rnd48(),
			32'h0a00_0001, cur_local_ip));
		push_item(FUNC_HEADER, hdr(MIN_FRAME_LEN, 16'hffff, PROTO_IPV4, OP_REQUEST, rnd48(),
			32'h0a00_0001, cur_local_ip));
		push_item(FUNC_HEADER, hdr(MIN_FRAME_LEN, HW_ETHERNET, 16'h0008, OP_REQUEST, rnd48(),
			32'h0a00_0001, cur_local_ip));
		push_item(FUNC_HEADER, hdr(MIN_FRAME_LEN, HW_ETHERNET, 16'hffff, OP_REQUEST, rnd48(),
			32'h0a00_0001, cur_local_ip));
		// Request for the local address from a full-ones MAC: a reply.
		push_item(FUNC_HEADER, hdr(16'hffff, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1,
			32'h0a00_0001, cur_local_ip));
		// Sender IP zero leaves its slot empty but stores the MAC; a lookup of 0 finds it.
		push_item(FUNC_HEADER, hdr(MIN_FRAME_LEN, HW_ETHERNET, PROTO_IPV4, 16'd2,
			48'h1234_5678_9abc, '0, cur_local_ip));
		push_item(FUNC_LOOKUP, look('0));
		// A known sender gets its MAC rewritten; a request for another host gets no reply.
		push_item(FUNC_HEADER, hdr(16'd100, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '0,
			32'h0a00_0001, '1));
		push_item(FUNC_LOOKUP, look(32'h0a00_0001));
		// Opcodes other than a request are only learned.
		push_item(FUNC_HEADER, hdr(16'd60, HW_ETHERNET, PROTO_IPV4, 16'h0000, rnd48(),
			'1, cur_local_ip));
		push_item(FUNC_HEADER, hdr(16'd60, HW_ETHERNET, PROTO_IPV4, 16'hffff, rnd48(),
			32'h0a00_0002, '0));
		// Fill the cache, then one more sender that finds no room but still gets a reply.
		for (int k = 3; k <= 8; k++) begin
			push_item(FUNC_HEADER, hdr(16'(28 + k), HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
				rnd48(), 32'h0a00_0000 + 32'(k), cur_local_ip));
		end
		push_item(FUNC_LOOKUP, look(32'h0a00_0008));
		push_item(FUNC_LOOKUP, look('0));
		push_item(FUNC_LOOKUP, look(32'h0a00_0005));
		push_item(FUNC_LOOKUP, look('1));

		// Random phases, each under its own register setting.
		drain();
		write_reg(REG_LOCAL_MAC, '0);
		write_reg(REG_LOCAL_IP, 48'h0a00_0005);
		run_random(250);
		drain();
		write_reg(REG_LOCAL_MAC, '1);
		write_reg(REG_LOCAL_IP, '0);
		run_random(250);
		drain();
		write_reg(REG_LOCAL_MAC, rnd48());
		write_reg(REG_LOCAL_IP, 48'h0000_ffff_ffff);
		run_random(250);
		drain();
		quiet_tail = 1'b1;
		write_reg(REG_LOCAL_MAC, LOCAL_MAC_RESET);
		write_reg(REG_LOCAL_IP, {16'h0000, $urandom});
		run_random(250);

		// Let the last results out, then a short tail for stray beats.
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (ENTRIES_DEF + 4) @(negedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
